### hw/rtl/cst_pkg.sv
// Shared constants, codes and types of the connection slot table.
package cst_pkg;

    // Table geometry.
    localparam int SLOTS     = 64;
    localparam int KEY_BITS  = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    // Fixed widths of the channel fields.
    localparam int MODE_W = 4;
    localparam int KEY_W  = 16;
    localparam int SID_W  = 8;
    localparam int RID_W  = 6;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [MODE_W-1:0]    mode_t;

    // Operation codes.
    localparam mode_t MODE_ALLOC         = 4'd0;
    localparam mode_t MODE_ATTACH        = 4'd1;
    localparam mode_t MODE_REL_ID        = 4'd2;
    localparam mode_t MODE_REL_CHAN      = 4'd3;
    localparam mode_t MODE_REMAP         = 4'd4;
    localparam mode_t MODE_ID_BY_CHAN    = 4'd5;
    localparam mode_t MODE_ID_BY_CTRL    = 4'd6;
    localparam mode_t MODE_CHAN_BY_ID    = 4'd7;
    localparam mode_t MODE_MEDIA_BY_ID   = 4'd8;
    localparam mode_t MODE_MEDIA_BY_CHAN = 4'd9;

    // Which test the scan applies to each entry read.
    typedef enum logic [2:0] {
        COL_CHAN,
        COL_MEDIA,
        COL_CTRL,
        COL_EMPTY,
        COL_ANY
    } col_t;

    // Where a scan starts.
    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_NEXT,
        ADDR_SID
    } addr_src_t;

    // One slot as stored in the table memory.
    typedef struct packed {
        key_t chan;
        key_t media;
        key_t ctrl;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      start;
        addr_src_t src;
        col_t      col;
        logic      issue;
        logic      finish;
    } cst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  key_zero;
        logic  sid_ok;
        logic  hit;
        logic  rd_pending;
        logic  out_busy;
    } cst_status_t;

endpackage

### hw/rtl/cst_req_if.sv
// Request channel of the connection slot table: one operation per beat.
interface cst_req_if;
    import cst_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  chan_key;
    logic [KEY_W-1:0]  media_key;
    logic [KEY_W-1:0]  ctrl_key;
    logic [SID_W-1:0]  slot_id;

    modport source (
        output valid, mode, chan_key, media_key, ctrl_key, slot_id,
        input  ready
    );

    modport sink (
        input  valid, mode, chan_key, media_key, ctrl_key, slot_id,
        output ready
    );

endinterface

### hw/rtl/cst_rsp_if.sv
// Response channel of the connection slot table: one result per beat.
interface cst_rsp_if;
    import cst_pkg::*;

    logic             valid;
    logic             ready;
    logic             ok;
    logic [RID_W-1:0] result_id;
    logic [KEY_W-1:0] result_key;

    modport source (
        output valid, ok, result_id, result_key,
        input  ready
    );

    modport sink (
        input  valid, ok, result_id, result_key,
        output ready
    );

endinterface

### hw/rtl/cst_datapath.sv
// Datapath of the connection slot table: slot memory, scan compare and result register.
module cst_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cst_pkg::cst_cmd_t        cmd,
    output cst_pkg::cst_status_t     status,
    input  logic [cst_pkg::MODE_W-1:0] in_mode,
    input  logic [cst_pkg::KEY_W-1:0]  in_chan_key,
    input  logic [cst_pkg::KEY_W-1:0]  in_media_key,
    input  logic [cst_pkg::KEY_W-1:0]  in_ctrl_key,
    input  logic [cst_pkg::SID_W-1:0]  in_slot_id,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_ok,
    output logic [cst_pkg::RID_W-1:0]  out_result_id,
    output logic [cst_pkg::KEY_W-1:0]  out_result_key
);
    import cst_pkg::*;

    // Captured request.
    mode_t            mode_reg;
    key_t             chan_reg;
    key_t             media_reg;
    key_t             ctrl_reg;
    logic [SID_W-1:0] sid_reg;

    // Slot memory and per-slot valid bits; an invalid slot reads as all zero.
    entry_t            mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  valid_next;

    // Scan state.
    slot_t  addr_reg;
    slot_t  addr_next;
    col_t   col_reg;
    col_t   col_next;
    entry_t rd_raw_reg;
    logic   rd_vbit_reg;
    slot_t  rd_idx_reg;
    logic   rd_vld_reg;
    logic   found_reg;
    logic   found_next;
    entry_t hit_word_reg;
    slot_t  hit_idx_reg;
    slot_t  last_alloc_reg;
    slot_t  last_alloc_next;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_ok_reg;
    logic [RID_W-1:0] out_id_reg;
    logic [KEY_W-1:0] out_key_reg;

    entry_t rd_word;
    logic   match;
    logic   hit;
    slot_t  next_after_last;

    // Outcome of the finishing cycle.
    logic   fin_ok;
    slot_t  fin_rid;
    key_t   fin_rkey;
    logic   fin_wr;
    entry_t fin_wdata;
    logic   fin_set_v;
    logic   fin_clr_v;
    logic   fin_new;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            chan_reg  <= KEY_BITS'(in_chan_key);
            media_reg <= KEY_BITS'(in_media_key);
            ctrl_reg  <= KEY_BITS'(in_ctrl_key);
            sid_reg   <= in_slot_id;
        end
    end

    // Compare of the entry read in the previous cycle.
    always_comb
    begin
        rd_word = rd_vbit_reg ? rd_raw_reg : '0;
        case (col_reg)
            COL_CHAN:  match = (rd_word.chan == chan_reg);
            COL_MEDIA: match = (rd_word.media == media_reg);
            COL_CTRL:  match = (rd_word.ctrl == ctrl_reg);
            COL_EMPTY: match = (rd_word.chan == '0);
            COL_ANY:   match = 1'b1;
            default:   match = 1'b0;
        endcase
        hit = rd_vld_reg && match;
    end

    assign next_after_last = (last_alloc_reg == SLOT_BITS'(SLOTS - 1)) ? '0
                                                                      : last_alloc_reg + 1'b1;

    // Scan address and column control.
    always_comb
    begin
        addr_next  = addr_reg;
        col_next   = col_reg;
        found_next = found_reg;
        if (cmd.capture)
        begin
            found_next = 1'b0;
        end
        if (cmd.start)
        begin
            col_next   = cmd.col;
            found_next = 1'b0;
            case (cmd.src)
                ADDR_ZERO: addr_next = '0;
                ADDR_NEXT: addr_next = next_after_last;
                ADDR_SID:  addr_next = SLOT_BITS'(sid_reg);
                default:   addr_next = '0;
            endcase
        end
        else if (cmd.issue)
        begin
            addr_next = (addr_reg == SLOT_BITS'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
        end
        if (hit)
        begin
            found_next = 1'b1;
        end
    end

    // Decide the result and the table update from the first hit of the scan.
    always_comb
    begin
        fin_ok    = 1'b0;
        fin_rid   = '0;
        fin_rkey  = '0;
        fin_wr    = 1'b0;
        fin_wdata = hit_word_reg;
        fin_set_v = 1'b0;
        fin_clr_v = 1'b0;
        fin_new   = 1'b0;
        case (mode_reg)
            MODE_ALLOC:
            begin
                if (found_reg && chan_reg != '0)
                begin
                    fin_ok  = 1'b1;
                    fin_rid = hit_idx_reg;
                    if (col_reg == COL_EMPTY)
                    begin
                        fin_wr          = 1'b1;
                        fin_set_v       = 1'b1;
                        fin_new         = 1'b1;
                        fin_wdata.chan  = chan_reg;
                        fin_wdata.media = '0;
                        fin_wdata.ctrl  = ctrl_reg;
                    end
                end
            end
            MODE_ATTACH:
            begin
                if (found_reg && hit_word_reg.chan != '0)
                begin
                    fin_ok          = 1'b1;
                    fin_rid         = hit_idx_reg;
                    fin_wr          = 1'b1;
                    fin_set_v       = 1'b1;
                    fin_wdata.media = media_reg;
                end
            end
            MODE_REL_ID:
            begin
                if (found_reg && hit_word_reg.chan != '0)
                begin
                    fin_ok    = 1'b1;
                    fin_rid   = hit_idx_reg;
                    fin_clr_v = 1'b1;
                end
            end
            MODE_REL_CHAN:
            begin
                if (found_reg && chan_reg != '0)
                begin
                    fin_ok    = 1'b1;
                    fin_rid   = hit_idx_reg;
                    fin_clr_v = 1'b1;
                end
            end
            MODE_REMAP:
            begin
                if (found_reg && hit_word_reg.chan != chan_reg)
                begin
                    fin_ok         = 1'b1;
                    fin_rid        = hit_idx_reg;
                    fin_wr         = 1'b1;
                    fin_set_v      = 1'b1;
                    fin_wdata.chan = chan_reg;
                    fin_wdata.ctrl = ctrl_reg;
                end
            end
            MODE_ID_BY_CHAN, MODE_ID_BY_CTRL:
            begin
                if (found_reg)
                begin
                    fin_ok  = 1'b1;
                    fin_rid = hit_idx_reg;
                end
            end
            MODE_CHAN_BY_ID:
            begin
                fin_rkey = found_reg ? hit_word_reg.chan : '0;
                fin_ok   = (fin_rkey != '0);
            end
            MODE_MEDIA_BY_ID, MODE_MEDIA_BY_CHAN:
            begin
                fin_rkey = found_reg ? hit_word_reg.media : '0;
                fin_ok   = (fin_rkey != '0);
            end
            default:
            begin
                fin_ok = 1'b0;
            end
        endcase
    end

    // Valid bits, allocation pointer and result handshake.
    always_comb
    begin
        valid_next      = valid_reg;
        last_alloc_next = last_alloc_reg;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (fin_set_v)
            begin
                valid_next[hit_idx_reg] = 1'b1;
            end
            if (fin_clr_v)
            begin
                valid_next[hit_idx_reg] = 1'b0;
            end
            if (fin_new)
            begin
                last_alloc_next = hit_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            addr_reg       <= '0;
            col_reg        <= COL_CHAN;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            last_alloc_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            addr_reg       <= addr_next;
            col_reg        <= col_next;
            rd_vld_reg     <= cmd.issue;
            found_reg      <= found_next;
            last_alloc_reg <= last_alloc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Memory port, read pipeline and first-hit capture.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && fin_wr)
        begin
            mem[hit_idx_reg] <= fin_wdata;
        end
        if (cmd.issue)
        begin
            rd_raw_reg  <= mem[addr_reg];
            rd_vbit_reg <= valid_reg[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
        if (hit && !found_reg)
        begin
            hit_word_reg <= rd_word;
            hit_idx_reg  <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            out_ok_reg  <= fin_ok;
            out_id_reg  <= fin_ok ? RID_W'(fin_rid) : '0;
            out_key_reg <= KEY_W'(fin_rkey);
        end
    end

    assign status.mode       = mode_reg;
    assign status.key_zero   = (chan_reg == '0);
    assign status.sid_ok     = (int'(sid_reg) < SLOTS);
    assign status.hit        = hit;
    assign status.rd_pending = rd_vld_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign out_ok         = out_ok_reg;
    assign out_result_id  = out_id_reg;
    assign out_result_key = out_key_reg;

    // A finished scan that is reported as found has a hit captured behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        hit && !found_reg |=> found_reg)
        else $error("first hit of a scan was not recorded");

    // The result register is loaded only when it is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while the receiver stalls");

    // A new allocation never lands on the slot allocated last.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && fin_new |-> hit_idx_reg != last_alloc_reg)
        else $error("allocation reused the last allocated slot");

endmodule

### hw/rtl/cst_ctrl.sv
// Controller of the connection slot table: sequences each operation's scan and result.
module cst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output cst_pkg::cst_cmd_t    cmd,
    input  cst_pkg::cst_status_t status
);
    import cst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DISPATCH = 4'b0010,
        S_SCAN     = 4'b0100,
        S_FINISH   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    cnt_t   cnt_reg;
    cnt_t   cnt_next;
    cnt_t   total_reg;
    cnt_t   total_next;
    logic   rr_reg;
    logic   rr_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        rr_next    = rr_reg;
        cmd        = '0;
        cmd.src    = ADDR_ZERO;
        cmd.col    = COL_CHAN;
        in_ready   = 1'b0;
        case (state_reg)
            // Wait for a request beat.
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            // Choose the scan that the operation needs.
            S_DISPATCH:
            begin
                cnt_next   = '0;
                rr_next    = 1'b0;
                total_next = CNT_BITS'(SLOTS);
                state_next = S_SCAN;
                cmd.start  = 1'b1;
                cmd.src    = ADDR_ZERO;
                case (status.mode)
                    MODE_ALLOC, MODE_REL_CHAN:
                    begin
                        cmd.col = COL_CHAN;
                        if (status.key_zero)
                        begin
                            cmd.start  = 1'b0;
                            state_next = S_FINISH;
                        end
                    end
                    MODE_REMAP:
                    begin
                        cmd.col = COL_MEDIA;
                    end
                    MODE_ID_BY_CHAN, MODE_MEDIA_BY_CHAN:
                    begin
                        cmd.col = COL_CHAN;
                    end
                    MODE_ID_BY_CTRL:
                    begin
                        cmd.col = COL_CTRL;
                    end
                    MODE_ATTACH, MODE_REL_ID, MODE_CHAN_BY_ID, MODE_MEDIA_BY_ID:
                    begin
                        cmd.src    = ADDR_SID;
                        cmd.col    = COL_ANY;
                        total_next = CNT_BITS'(1);
                        if (!status.sid_ok)
                        begin
                            cmd.start  = 1'b0;
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        cmd.start  = 1'b0;
                        state_next = S_FINISH;
                    end
                endcase
            end
            // Issue one read a cycle until a hit or the end of the range.
            S_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (cnt_reg == total_reg && !status.rd_pending)
                begin
                    if (status.mode == MODE_ALLOC && !rr_reg)
                    begin
                        // Round-robin search for a free slot after the last allocated one.
                        cmd.start  = 1'b1;
                        cmd.src    = ADDR_NEXT;
                        cmd.col    = COL_EMPTY;
                        cnt_next   = '0;
                        total_next = CNT_BITS'(SLOTS - 1);
                        rr_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (cnt_reg != total_reg)
                begin
                    cmd.issue = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            // Load the response register once it is free.
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            total_reg <= '0;
            rr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            rr_reg    <= rr_next;
        end
    end

    // Reads are issued only while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> state_reg == S_SCAN)
        else $error("read issued outside a scan");

    // The read count never runs past the scan range.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cnt_reg <= total_reg)
        else $error("scan ran past its range");

    // An accepted request is always followed by dispatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_DISPATCH)
        else $error("request beat not dispatched");

    // Only allocation runs the second, round-robin scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        rr_reg && state_reg == S_SCAN |-> status.mode == MODE_ALLOC)
        else $error("round-robin scan outside allocation");

endmodule

### hw/rtl/connection_slot_table.sv
// Top level of the connection slot table: controller and datapath joined by commands.
//
// Requests arrive on req, one operation per beat (mode, chan_key, media_key,
// ctrl_key, slot_id); each gives exactly one response beat on rsp (ok,
// result_id, result_key), in order. Operations run one at a time: req.ready
// is high only while no operation is in progress, and the next request beat
// is taken at the earliest in the cycle after the response has been loaded.
// Operations by slot number capture the request, dispatch it, read the one
// slot, compare it and then load the response; an invalid slot number, a
// zero key where it is refused, or an undefined operation code skips the
// read and loads the response straight after dispatch. Operations by key read
// the slot memory once a cycle from slot 0 and stop at the first match. An
// allocation of a new key also runs a round-robin search for a free slot
// after the one allocated last. The slot memory has a single read port.
// Reset empties every slot at once through per-slot valid bits, so the
// block takes requests from the first cycle after reset; no clearing pass.
// The response is held in a register: while the receiver stalls it stays on
// rsp, and the block finishes the next operation only once it is taken.
module connection_slot_table (
    input  logic      clk,
    input  logic      rst_n,
    cst_req_if.sink   req,
    cst_rsp_if.source rsp
);
    import cst_pkg::*;

    cst_cmd_t    cmd;
    cst_status_t status;
    logic        in_ready;

    assign req.ready = in_ready;

    cst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    cst_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_mode        (req.mode),
        .in_chan_key    (req.chan_key),
        .in_media_key   (req.media_key),
        .in_ctrl_key    (req.ctrl_key),
        .in_slot_id     (req.slot_id),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_ok         (rsp.ok),
        .out_result_id  (rsp.result_id),
        .out_result_key (rsp.result_key)
    );

endmodule
